// ===== hw/rtl/rstt_pkg.sv =====
package rstt_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;

    localparam logic [15:0] COUNT_FOREVER = 16'hFFFF;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    typedef struct packed {
        logic [63:0] deadline;
        logic [31:0] period;
        logic [15:0] remaining;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic finish;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic ev_ready;
    } stat_t;

endpackage

// ===== hw/rtl/rstt_ram.sv =====
module rstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/rstt_ctrl.sv =====
module rstt_ctrl import rstt_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       cmd,
    input  stat_t            st,
    output ctl_t             ctl,
    output logic [IDX_W-1:0] idx,
    output logic [IDX_W-1:0] rd_addr
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign idx      = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rd_addr    = idx_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                rd_addr  = '0;
                ctl.load = accept;
                if (accept)
                begin
                    idx_next   = '0;
                    state_next = (cmd == CMD_TICK) ? S_SCAN : S_CMD;
                end
            end
            S_CMD:
            begin
                ctl.exec = 1'b1;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (st.ev_ready)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            S_END:
            begin
                ctl.finish = 1'b1;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== hw/rtl/rstt_dp.sv =====
module rstt_dp import rstt_pkg::*; #(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         cmd,
    input  logic [3:0]         timer_id,
    input  logic [31:0]        period,
    input  logic signed [15:0] repeat_count,
    input  ctl_t               ctl,
    input  logic [IDX_W-1:0]   idx,
    input  logic [IDX_W-1:0]   rd_addr,
    output stat_t              st,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               fired,
    output logic [3:0]         fired_id,
    output logic               error,
    output logic               last
);

    logic [1:0]            cmd_reg, cmd_next;
    logic [3:0]            id_reg, id_next;
    logic [31:0]           per_reg, per_next;
    logic [15:0]           rep_reg, rep_next;

    logic [63:0]           tick_reg, tick_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [3:0]            pend_id_reg, pend_id_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  fired_reg, fired_next;
    logic [3:0]            fired_id_reg, fired_id_next;
    logic                  error_reg, error_next;
    logic                  last_reg, last_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    slot_t                 ram_wdata;
    slot_t                 rd;

    logic                  out_free, hit, report, need_out, ev_ready, push;
    logic                  id_ok;
    logic [15:0]           rem_dec;
    logic [IDX_W-1:0]      cid;

    rstt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign hit      = armed_reg[idx] && (rd.deadline == tick_reg);
    assign rem_dec  = (rd.remaining == COUNT_FOREVER) ? rd.remaining : rd.remaining - 16'd1;
    assign report   = hit && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign need_out = report && pend_valid_reg;
    assign ev_ready = !need_out || out_free;
    assign id_ok    = {5'd0, id_reg} < 9'(NUM_TIMERS);
    assign cid      = IDX_W'(id_reg);

    assign st.out_free = out_free;
    assign st.ev_ready = ev_ready;

    always_comb
    begin
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        per_next        = per_reg;
        rep_next        = rep_reg;
        tick_next       = tick_reg;
        armed_next      = armed_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        cnt_next        = cnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx;
        ram_wdata       = '0;
        push            = 1'b0;
        fired_next      = fired_reg;
        fired_id_next   = fired_id_reg;
        error_next      = error_reg;
        last_next       = last_reg;

        if (ctl.load)
        begin
            cmd_next = cmd;
            id_next  = timer_id;
            per_next = period;
            rep_next = repeat_count;
        end

        if (ctl.scan && ev_ready)
        begin
            if (hit)
            begin
                ram_we             = 1'b1;
                ram_waddr          = idx;
                ram_wdata.deadline = tick_reg + {32'd0, rd.period};
                ram_wdata.period   = rd.period;
                ram_wdata.remaining = rem_dec;
                armed_next[idx]    = (rem_dec != 16'd0);
            end
            if (report)
            begin
                if (pend_valid_reg)
                begin
                    push          = 1'b1;
                    fired_next    = 1'b1;
                    fired_id_next = pend_id_reg;
                    error_next    = 1'b0;
                    last_next     = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_id_next    = 4'(idx);
                cnt_next        = cnt_reg + 1'b1;
            end
        end

        if (ctl.finish && out_free)
        begin
            push            = 1'b1;
            fired_next      = pend_valid_reg;
            fired_id_next   = pend_valid_reg ? pend_id_reg : 4'd0;
            error_next      = 1'b0;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
            cnt_next        = '0;
            tick_next       = tick_reg + 64'd1;
        end

        if (ctl.exec && out_free)
        begin
            push          = 1'b1;
            fired_next    = 1'b0;
            fired_id_next = 4'd0;
            error_next    = 1'b0;
            last_next     = 1'b1;
            case (cmd_reg)
                CMD_ADD:
                begin
                    if (per_reg == 32'd0 && rep_reg == COUNT_FOREVER)
                    begin
                        error_next = 1'b1;
                    end
                    else if (id_ok && rep_reg != 16'd0)
                    begin
                        if (per_reg == 32'd0)
                        begin
                            armed_next[cid] = 1'b0;
                            fired_next      = 1'b1;
                            fired_id_next   = id_reg;
                        end
                        else
                        begin
                            ram_we              = 1'b1;
                            ram_waddr           = cid;
                            ram_wdata.deadline  = tick_reg + {32'd0, per_reg};
                            ram_wdata.period    = per_reg;
                            ram_wdata.remaining = rep_reg;
                            armed_next[cid]     = 1'b1;
                        end
                    end
                end
                CMD_DEL:
                begin
                    if (id_ok)
                    begin
                        armed_next[cid] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            armed_reg      <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_reg       <= tick_next;
            armed_reg      <= armed_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        per_reg      <= per_next;
        rep_reg      <= rep_next;
        pend_id_reg  <= pend_id_next;
        fired_reg    <= fired_next;
        fired_id_reg <= fired_id_next;
        error_reg    <= error_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign fired     = fired_reg;
    assign fired_id  = fired_id_reg;
    assign error     = error_reg;
    assign last      = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("firing count above limit");

    a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> cnt_reg != '0)
        else $error("pending firing with zero count");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish && out_free |=> !pend_valid_reg && cnt_reg == '0)
        else $error("tick end left firing state behind");

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg != $past(tick_reg) |-> tick_reg == $past(tick_reg) + 64'd1)
        else $error("tick count moved by other than one");

endmodule

// ===== hw/rtl/repeating_software_timer_table_top.sv =====
// Command-driven table of NUM_TIMERS repeating timers with 64-bit deadlines kept in one
// slot RAM. An add or delete transaction passes through the command state and yields one
// result. A tick transaction walks the slot RAM one slot per cycle unless the output side
// stalls, comparing each armed deadline with the tick count and writing the re-armed slot
// back, then closes the tick in the end state and advances the tick count.
// Firings come out in ascending slot order, at most 16 per tick, with last marking the
// final result of each command.
module repeating_software_timer_table_top import rstt_pkg::*; #(
    parameter int NUM_TIMERS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [3:0]         timer_id,
    input  logic [31:0]        period,
    input  logic signed [15:0] repeat_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               fired,
    output logic [3:0]         fired_id,
    output logic               error,
    output logic               last
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    ctl_t             ctl;
    stat_t            st;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rd_addr;

    rstt_ctrl #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .st       (st),
        .ctl      (ctl),
        .idx      (idx),
        .rd_addr  (rd_addr)
    );

    rstt_dp #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .timer_id     (timer_id),
        .period       (period),
        .repeat_count (repeat_count),
        .ctl          (ctl),
        .idx          (idx),
        .rd_addr      (rd_addr),
        .st           (st),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .fired        (fired),
        .fired_id     (fired_id),
        .error        (error),
        .last         (last)
    );

endmodule
